/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the sequence-to-MIDI transcoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SQME_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SQME_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sqme_pkg.sv */
// ---------------------------------------------------------------------------
// sqme_pkg
// Types, constants and control/status bundles of the MIDI event transcoder.
// ---------------------------------------------------------------------------
package sqme_pkg;

  // Default width of the decoded SysEx length.
  localparam int SYSEX_LEN_BITS_DEF = 28;
  // Four varlen groups of seven bits cover any supported length.
  localparam int VLQ_BITS = 28;

  // Tempo conversion: microseconds per minute over bpm.
  localparam int          TEMPO_STEPS = 26;
  localparam logic [25:0] TEMPO_NUM   = 26'd60000000;
  localparam logic [23:0] TEMPO_DEF   = 24'h07A120;  // 500000 us
  localparam logic [7:0]  TEMPO_LEN   = 8'h03;

  // Byte codes.
  localparam logic [7:0] META_BYTE  = 8'hFF;
  localparam logic [7:0] SYSEX_F0   = 8'hF0;
  localparam logic [7:0] SYSEX_F7   = 8'hF7;
  localparam logic [7:0] META_EOT   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [3:0] CMD_BEND   = 4'hE;
  localparam logic [3:0] CMD_PROG   = 4'hC;
  localparam logic [3:0] CMD_PRESS  = 4'hD;
  localparam logic [3:0] CMD_SYS    = 4'hF;

  // What the output buffer is loaded with.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_BYTE,
    EM_EOT,
    EM_BEND,
    EM_TEMPO_LEN,
    EM_TEMPO_DEF,
    EM_TEMPO_DIV,
    EM_VARLEN
  } emit_t;

  // Controller to datapath commands.
  typedef struct packed {
    emit_t emit;
    logic  run_set;
    logic  run_clr;
    logic  cur_from_b;
    logic  cur_from_run;
    logic  acc_clr;
    logic  acc_shift;
    logic  bl_from_b;
    logic  bl_from_acc;
    logic  bl_dec;
    logic  div_start;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic b_chan;
    logic b_sys;
    logic b_hi;
    logic b_meta;
    logic b_sysex;
    logic b_eot;
    logic b_tempo;
    logic b_one;
    logic b_zero;
    logic run_zero;
    logic run_bend;
    logic run_short;
    logic cur_bend;
    logic cur_short;
    logic bl_one;
    logic acc_zero;
    logic div_done;
    logic buf_free;
  } dp_stat_t;

endpackage

/* rtl/sqme_div.sv */
// ---------------------------------------------------------------------------
// sqme_div
// Restoring divider, one quotient bit per cycle: 60000000 / bpm.
// ---------------------------------------------------------------------------
module sqme_div
  import sqme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [23:0] quot
);

  localparam int CNT_W = $clog2(TEMPO_STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       rem_r;
  logic [7:0]       dvs_r;
  logic [23:0]      quo_r;
  logic [8:0]       trial;
  logic [8:0]       diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtract.
  assign trial = {rem_r, TEMPO_NUM[cnt_r]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Control: run for one step per dividend bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(TEMPO_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[7:0] : trial[7:0];
      quo_r <= {quo_r[22:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* rtl/sqme_dp.sv */
// ---------------------------------------------------------------------------
// sqme_dp
// Datapath: byte decode, status/length registers, tempo divider and the
// output byte buffer.
// ---------------------------------------------------------------------------
module sqme_dp
  import sqme_pkg::*;
#(
  parameter int SYSEX_LEN_BITS = SYSEX_LEN_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [7:0] in_byte,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  logic     out_ready,
  output logic     out_valid,
  output logic [7:0] out_byte,
  output logic     out_last,
  output logic     out_end
);

  localparam int LW   = SYSEX_LEN_BITS;
  localparam int BL_W = (LW > 8) ? LW : 8;

  logic [7:0]      run_r;
  logic [3:0]      cur_r;
  logic [BL_W-1:0] bl_r;
  logic [LW-1:0]   acc_r;
  logic [LW+6:0]   acc_sh;
  logic [LW-1:0]   acc_v;
  logic [VLQ_BITS-1:0] v28;
  logic            g1, g2, g3;

  logic [7:0]      obuf_r [4];
  logic [2:0]      ocnt_r;
  logic            te_r;
  logic [7:0]      nbuf [4];
  logic [2:0]      ncnt;
  logic            pop;

  logic [15:0]     bend;
  logic            div_done;
  logic [23:0]     div_q;

  // Next SysEx length accumulation and its varlen group count.
  assign acc_sh = {acc_r, in_byte[6:0]};
  assign acc_v  = acc_sh[LW-1:0];
  assign v28    = VLQ_BITS'(acc_v);
  assign g1     = |v28[27:7];
  assign g2     = |v28[27:14];
  assign g3     = |v28[27:21];

  // Pitch bend scaling: v * 16383 / 127 is exactly v * 129.
  assign bend = {1'b0, in_byte, 7'b0} + {8'b0, in_byte};

  sqme_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (in_byte),
    .done    (div_done),
    .quot    (div_q)
  );

  // Decode the incoming byte and report register conditions.
  always_comb begin
    stat.b_chan    = in_byte[7] && (in_byte[7:4] != CMD_SYS);
    stat.b_sys     = (in_byte[7:4] == CMD_SYS);
    stat.b_hi      = in_byte[7];
    stat.b_meta    = (in_byte == META_BYTE);
    stat.b_sysex   = (in_byte == SYSEX_F0) || (in_byte == SYSEX_F7);
    stat.b_eot     = (in_byte == META_EOT);
    stat.b_tempo   = (in_byte == META_TEMPO);
    stat.b_one     = (in_byte == 8'd1);
    stat.b_zero    = (in_byte == 8'd0);
    stat.run_zero  = (run_r == 8'd0);
    stat.run_bend  = (run_r[7:4] == CMD_BEND);
    stat.run_short = (run_r[7:4] == CMD_PROG) || (run_r[7:4] == CMD_PRESS);
    stat.cur_bend  = (cur_r == CMD_BEND);
    stat.cur_short = (cur_r == CMD_PROG) || (cur_r == CMD_PRESS);
    stat.bl_one    = (bl_r == BL_W'(1));
    stat.acc_zero  = (acc_v == '0);
    stat.div_done  = div_done;
    stat.buf_free  = (ocnt_r == 3'd0) || ((ocnt_r == 3'd1) && out_ready);
  end

  // Status and length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      cur_r <= '0;
      bl_r  <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.run_set) begin
        run_r <= in_byte;
      end else if (cmd.run_clr) begin
        run_r <= '0;
      end
      if (cmd.cur_from_b) begin
        cur_r <= in_byte[7:4];
      end else if (cmd.cur_from_run) begin
        cur_r <= run_r[7:4];
      end
      if (cmd.acc_clr) begin
        acc_r <= '0;
      end else if (cmd.acc_shift) begin
        acc_r <= acc_v;
      end
      if (cmd.bl_from_b) begin
        bl_r <= BL_W'(in_byte);
      end else if (cmd.bl_from_acc) begin
        bl_r <= BL_W'(acc_v);
      end else if (cmd.bl_dec) begin
        bl_r <= bl_r - BL_W'(1);
      end
    end
  end

  // Form the result bytes of this request.
  always_comb begin
    nbuf[0] = in_byte;
    nbuf[1] = '0;
    nbuf[2] = '0;
    nbuf[3] = '0;
    ncnt    = 3'd0;
    unique case (cmd.emit)
      EM_NONE: begin
        ncnt = 3'd0;
      end
      EM_BYTE, EM_EOT: begin
        ncnt = 3'd1;
      end
      EM_BEND: begin
        nbuf[0] = {1'b0, bend[6:0]};
        nbuf[1] = {1'b0, bend[13:7]};
        ncnt    = 3'd2;
      end
      EM_TEMPO_LEN: begin
        nbuf[0] = TEMPO_LEN;
        ncnt    = 3'd1;
      end
      EM_TEMPO_DEF: begin
        nbuf[0] = TEMPO_DEF[23:16];
        nbuf[1] = TEMPO_DEF[15:8];
        nbuf[2] = TEMPO_DEF[7:0];
        ncnt    = 3'd3;
      end
      EM_TEMPO_DIV: begin
        nbuf[0] = div_q[23:16];
        nbuf[1] = div_q[15:8];
        nbuf[2] = div_q[7:0];
        ncnt    = 3'd3;
      end
      EM_VARLEN: begin
        priority if (g3) begin
          nbuf[0] = {1'b1, v28[27:21]};
          nbuf[1] = {1'b1, v28[20:14]};
          nbuf[2] = {1'b1, v28[13:7]};
          nbuf[3] = {1'b0, v28[6:0]};
          ncnt    = 3'd4;
        end else if (g2) begin
          nbuf[0] = {1'b1, v28[20:14]};
          nbuf[1] = {1'b1, v28[13:7]};
          nbuf[2] = {1'b0, v28[6:0]};
          ncnt    = 3'd3;
        end else if (g1) begin
          nbuf[0] = {1'b1, v28[13:7]};
          nbuf[1] = {1'b0, v28[6:0]};
          ncnt    = 3'd2;
        end else begin
          nbuf[0] = {1'b0, v28[6:0]};
          ncnt    = 3'd1;
        end
      end
      default: begin
        ncnt = 3'd0;
      end
    endcase
  end

  assign pop = out_valid && out_ready;

  // Output buffer: load a new group or shift out the head byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 3'd0;
    end else if (cmd.emit != EM_NONE) begin
      ocnt_r <= ncnt;
    end else if (pop) begin
      ocnt_r <= ocnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      obuf_r <= nbuf;
      te_r   <= (cmd.emit == EM_EOT);
    end else if (pop) begin
      obuf_r[0] <= obuf_r[1];
      obuf_r[1] <= obuf_r[2];
      obuf_r[2] <= obuf_r[3];
    end
  end

  assign out_valid = (ocnt_r != 3'd0);
  assign out_byte  = obuf_r[0];
  assign out_last  = (ocnt_r == 3'd1);
  assign out_end   = te_r && (ocnt_r == 3'd1);

endmodule

/* rtl/sqme_ctrl.sv */
// ---------------------------------------------------------------------------
// sqme_ctrl
// Parser state machine: walks delta, status, data, meta and SysEx fields
// and issues datapath commands per accepted byte until end of track.
// ---------------------------------------------------------------------------
module sqme_ctrl
  import sqme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_EOT_LEN,
    PH_TEMPO_LEN,
    PH_TEMPO_VAL,
    PH_TEMPO_WAIT,
    PH_META_LEN,
    PH_META_DATA,
    PH_SYSEX_LEN,
    PH_SYSEX_DATA
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   fin_r, fin_nxt;
  logic   take;

  // Hold input while dividing or while the buffer still has more than a
  // final byte pending or that final byte is stalled.
  assign in_ready = (phase_r != PH_TEMPO_WAIT) && stat.buf_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.emit  = EM_NONE;
    phase_nxt = phase_r;
    fin_nxt   = fin_r;

    if (phase_r == PH_TEMPO_WAIT) begin
      // Load the quotient once the buffer can take it.
      if (stat.div_done && stat.buf_free) begin
        cmd.emit  = EM_TEMPO_DIV;
        phase_nxt = PH_DELTA;
      end
    end else if (take && !fin_r) begin
      unique case (phase_r)
        PH_DELTA: begin
          cmd.emit = EM_BYTE;
          if (!stat.b_hi) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          priority if (stat.b_chan) begin
            cmd.emit       = EM_BYTE;
            cmd.run_set    = 1'b1;
            cmd.cur_from_b = 1'b1;
            phase_nxt      = PH_DATA1;
          end else if (stat.b_sys) begin
            cmd.emit       = EM_BYTE;
            cmd.run_clr    = 1'b1;
            cmd.cur_from_b = 1'b1;
            priority if (stat.b_meta) begin
              phase_nxt = PH_META_TYPE;
            end else if (stat.b_sysex) begin
              cmd.acc_clr = 1'b1;
              phase_nxt   = PH_SYSEX_LEN;
            end else begin
              phase_nxt = PH_DELTA;
            end
          end else if (stat.run_zero) begin
            // No running status: treat the byte as a one-byte delta.
            cmd.emit = EM_BYTE;
          end else begin
            cmd.cur_from_run = 1'b1;
            priority if (stat.run_bend) begin
              cmd.emit  = EM_BEND;
              phase_nxt = PH_DELTA;
            end else if (stat.run_short) begin
              cmd.emit  = EM_BYTE;
              phase_nxt = PH_DELTA;
            end else begin
              cmd.emit  = EM_BYTE;
              phase_nxt = PH_DATA2;
            end
          end
        end
        PH_DATA1: begin
          priority if (stat.cur_bend) begin
            cmd.emit  = EM_BEND;
            phase_nxt = PH_DELTA;
          end else if (stat.cur_short) begin
            cmd.emit  = EM_BYTE;
            phase_nxt = PH_DELTA;
          end else begin
            cmd.emit  = EM_BYTE;
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          cmd.emit  = EM_BYTE;
          phase_nxt = PH_DELTA;
        end
        PH_META_TYPE: begin
          cmd.emit = EM_BYTE;
          priority if (stat.b_eot) begin
            phase_nxt = PH_EOT_LEN;
          end else if (stat.b_tempo) begin
            phase_nxt = PH_TEMPO_LEN;
          end else begin
            phase_nxt = PH_META_LEN;
          end
        end
        PH_EOT_LEN: begin
          cmd.emit  = EM_EOT;
          fin_nxt   = 1'b1;
          phase_nxt = PH_DELTA;
        end
        PH_TEMPO_LEN: begin
          cmd.emit = EM_TEMPO_LEN;
          priority if (stat.b_one) begin
            phase_nxt = PH_TEMPO_VAL;
          end else begin
            cmd.bl_from_b = 1'b1;
            phase_nxt     = stat.b_zero ? PH_DELTA : PH_META_DATA;
          end
        end
        PH_TEMPO_VAL: begin
          if (stat.b_zero) begin
            cmd.emit  = EM_TEMPO_DEF;
            phase_nxt = PH_DELTA;
          end else begin
            cmd.div_start = 1'b1;
            phase_nxt     = PH_TEMPO_WAIT;
          end
        end
        PH_META_LEN: begin
          cmd.emit      = EM_BYTE;
          cmd.bl_from_b = 1'b1;
          phase_nxt     = stat.b_zero ? PH_DELTA : PH_META_DATA;
        end
        PH_META_DATA, PH_SYSEX_DATA: begin
          cmd.emit   = EM_BYTE;
          cmd.bl_dec = 1'b1;
          if (stat.bl_one) begin
            phase_nxt = PH_DELTA;
          end
        end
        PH_SYSEX_LEN: begin
          cmd.acc_shift = 1'b1;
          if (!stat.b_hi) begin
            // Length complete: re-encode and start the data count.
            cmd.emit        = EM_VARLEN;
            cmd.bl_from_acc = 1'b1;
            cmd.acc_clr     = 1'b1;
            phase_nxt       = stat.acc_zero ? PH_DELTA : PH_SYSEX_DATA;
          end
        end
        default: begin
          phase_nxt = PH_DELTA;
        end
      endcase
    end
  end

  // Hold parser phase and end-of-track flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

/* rtl/sq_to_midi_event_converter.sv */
// ---------------------------------------------------------------------------
// sq_to_midi_event_converter
// Sequence track bytes in, Standard MIDI track bytes out, with running
// status, pitch bend scaling, tempo conversion and SysEx length re-encoding.
//
//   Channel | Direction | tdata        | tlast | tuser
//   in_     | slave     | in_byte      | -     | -
//   out_    | master    | out_byte     | last  | track_end
//
// A byte yielding at most one result is taken every cycle while out_tready
// is high. A byte yielding n results holds the input until the output buffer
// drains to its last byte. A tempo byte with nonzero bpm runs the bit-serial
// divider and holds the input until the quotient is loaded. Reset is
// synchronous and needs no clearing pass. Output stalls back up into in_tready.
// ---------------------------------------------------------------------------
module sq_to_midi_event_converter
  import sqme_pkg::*;
#(
  parameter int SYSEX_LEN_BITS = SYSEX_LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] track_end
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sqme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqme_dp #(
    .SYSEX_LEN_BITS (SYSEX_LEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_end   (out_tuser)
  );

endmodule

/* rtl/sqme_checker.sv */
// ---------------------------------------------------------------------------
// sqme_checker
// Port-level checks of the transcoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sqme_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // A stalled result holds its payload.
  `SQME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // End of track closes its request's group.
  `SQME_ASSERT_NOW(a_end_last, clk, rst_n, out_tvalid && out_tuser, out_tlast, "track end not on last byte")

  // Nothing follows the end-of-track byte.
  `SQME_ASSERT_NEXT(a_end_quiet, clk, rst_n, out_tvalid && out_tready && out_tuser, !out_tvalid, "result after track end")

  // A new request is taken only when the pending group is gone or leaving.
  `SQME_ASSERT_NOW(a_in_gap, clk, rst_n, in_tvalid && in_tready, !out_tvalid || (out_tready && out_tlast), "request taken over pending results")

endmodule

bind sq_to_midi_event_converter sqme_checker u_sqme_checker (.*);
